// File: rtl/core/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TEXT_DEF    = 4096;
    localparam int STACK_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int CHAR_W  = 8;
    localparam int REG_W   = 12;
    localparam int IDX_W   = 13;
    localparam int COLOR_W = 24;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Markup characters
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_C      = 8'h63;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;

    // Digits in a color escape
    localparam logic [2:0] HEX_DIGITS = 3'd6;

    // Result queue
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = 2;
    localparam int OUT_FILL_W = 3;
    localparam logic [OUT_FILL_W-1:0] OUT_STALL_AT = 3'd3;

    typedef struct packed {
        logic [IDX_W-1:0]   seg_start;
        logic [IDX_W-1:0]   seg_end;
        logic               line_break;
        logic               has_color;
        logic [COLOR_W-1:0] color_rgb;
        logic               stack_overflow;
        logic               last_segment;
    } seg_t;

    // Up to two segments per character: slot 0 closes on a command,
    // slot 1 is the final segment of the text
    typedef struct packed {
        logic [1:0]      v;
        seg_t [1:0]      item;
    } emit_t;

    // Non-hex characters count as zero
    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [3:0] r;
        r = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            r = c[3:0];
        end
        else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
        begin
            r = 4'(c[3:0] + 4'd9);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/mts_ram.sv
`timescale 1ns / 1ps

module mts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mts_parser.sv
`timescale 1ns / 1ps

module mts_parser #(
    parameter int MAX_TEXT    = mts_pkg::MAX_TEXT_DEF,
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [mts_pkg::CHAR_W-1:0]  char_code,
    input  logic                        last_char,
    input  logic                        region_on,
    output mts_pkg::emit_t              em
);

    localparam int PW = $clog2(MAX_TEXT + 1);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [PW:0]   MAX_POS = (PW + 1)'(MAX_TEXT);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_CMD,
        PH_HEX,
        PH_LITERAL
    } phase_t;

    phase_t                          phase_reg, phase_step, phase_next;
    logic [2:0]                      digit_reg, digit_step, digit_next;
    logic [mts_pkg::COLOR_W-1:0]     acc_reg, acc_step, acc_next;
    logic [PW-1:0]                   pos_reg, pos_next;
    logic [PW-1:0]                   start_reg, start_step, start_next;
    logic [PW-1:0]                   end_reg, end_step, end_next;
    logic                            cval_reg, cval_step, cval_next;
    logic [mts_pkg::COLOR_W-1:0]     color_reg, color_step, color_next;
    logic [CW-1:0]                   count_reg, count_step, count_next;
    logic                            ovf_reg, ovf_step, ovf_next;

    logic [PW:0]                     p1, p2;
    logic [PW-1:0]                   lim, lim2;
    logic [mts_pkg::COLOR_W-1:0]     acc_shift;
    logic                            is_dollar, is_c, is_r, is_n;
    logic                            cmd_emit, cmd_nl;
    logic                            wr_en, rd_en;
    logic [mts_pkg::COLOR_W-1:0]     rdata;

    function automatic logic [PW-1:0] sat(input logic [PW:0] v);
        return (v > MAX_POS) ? MAX_POS[PW-1:0] : v[PW-1:0];
    endfunction

    function automatic mts_pkg::seg_t mk_seg(
        input logic [PW-1:0]               s,
        input logic [PW-1:0]               e,
        input logic [PW-1:0]               lm,
        input logic                        nl,
        input logic                        fin,
        input logic                        cv,
        input logic [mts_pkg::COLOR_W-1:0] col,
        input logic                        ov
    );
        mts_pkg::seg_t r;
        logic [PW-1:0] ss, ee;
        ss = (s > lm) ? lm : s;
        ee = (e > lm) ? lm : e;
        if (ee < ss)
        begin
            ee = ss;
        end
        r.seg_start      = mts_pkg::IDX_W'(ss);
        r.seg_end        = mts_pkg::IDX_W'(ee);
        r.line_break     = nl;
        r.has_color      = cv;
        r.color_rgb      = cv ? col : '0;
        r.stack_overflow = ov;
        r.last_segment   = fin;
        return r;
    endfunction

    assign p1   = {1'b0, pos_reg} + (PW + 1)'(1);
    assign p2   = {1'b0, pos_reg} + (PW + 1)'(2);
    assign lim  = sat(p1);
    assign lim2 = sat(p2);

    assign acc_shift = {acc_reg[mts_pkg::COLOR_W-5:0], mts_pkg::hex_nibble(char_code)};
    assign is_dollar = (char_code == mts_pkg::CH_DOLLAR);
    assign is_c      = (char_code == mts_pkg::CH_C);
    assign is_r      = (char_code == mts_pkg::CH_R);
    assign is_n      = (char_code == mts_pkg::CH_N);

    // One character of parsing, before the end-of-text clear
    always_comb
    begin
        phase_step = phase_reg;
        digit_step = digit_reg;
        acc_step   = acc_reg;
        start_step = start_reg;
        end_step   = end_reg;
        cval_step  = cval_reg;
        color_step = color_reg;
        count_step = count_reg;
        ovf_step   = ovf_reg;
        cmd_emit   = 1'b0;
        cmd_nl     = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;

        case (phase_reg)
            PH_NORMAL:
            begin
                if (!is_dollar)
                begin
                    end_step = lim;
                end
                else
                begin
                    // fetch the entry below the top in case a pop follows
                    rd_en = 1'b1;
                    if (!last_char)
                    begin
                        phase_step = PH_CMD;
                    end
                end
            end
            PH_CMD:
            begin
                if (is_c)
                begin
                    digit_step = '0;
                    acc_step   = '0;
                    phase_step = PH_HEX;
                end
                else if (is_r || is_n)
                begin
                    cmd_emit   = 1'b1;
                    cmd_nl     = is_n;
                    start_step = lim;
                    end_step   = lim2;
                    if (is_r)
                    begin
                        if (count_reg != '0)
                        begin
                            count_step = count_reg - CW'(1);
                        end
                        cval_step  = (count_reg > CW'(1));
                        color_step = (count_reg > CW'(1)) ? rdata : '0;
                    end
                    phase_step = PH_LITERAL;
                end
                else
                begin
                    cmd_emit   = 1'b1;
                    start_step = pos_reg;
                    end_step   = lim;
                    phase_step = PH_NORMAL;
                end
            end
            PH_HEX:
            begin
                acc_step   = acc_shift;
                digit_step = digit_reg + 3'd1;
                if (digit_reg == mts_pkg::HEX_DIGITS - 3'd1 && !last_char)
                begin
                    if (count_reg < DEPTH_C)
                    begin
                        wr_en      = 1'b1;
                        count_step = count_reg + CW'(1);
                        cval_step  = 1'b1;
                        color_step = acc_shift;
                    end
                    else
                    begin
                        ovf_step = 1'b1;
                    end
                    cmd_emit   = 1'b1;
                    start_step = lim;
                    end_step   = lim2;
                    digit_step = '0;
                    phase_step = PH_LITERAL;
                end
            end
            default:
            begin
                phase_step = PH_NORMAL;
            end
        endcase
    end

    // Clear all per-text state after the last character
    always_comb
    begin
        if (last_char)
        begin
            phase_next = PH_NORMAL;
            digit_next = '0;
            acc_next   = '0;
            pos_next   = '0;
            start_next = '0;
            end_next   = '0;
            cval_next  = 1'b0;
            color_next = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            phase_next = phase_step;
            digit_next = digit_step;
            acc_next   = acc_step;
            pos_next   = ({1'b0, pos_reg} < MAX_POS) ? p1[PW-1:0] : pos_reg;
            start_next = start_step;
            end_next   = end_step;
            cval_next  = cval_step;
            color_next = color_step;
            count_next = count_step;
            ovf_next   = ovf_step;
        end
    end

    always_comb
    begin
        em.v[0]    = take && region_on && cmd_emit;
        em.v[1]    = take && region_on && last_char;
        em.item[0] = mk_seg(start_reg, end_reg, lim, cmd_nl, 1'b0,
                            cval_reg, color_reg, ovf_step);
        em.item[1] = mk_seg(start_step, end_step, lim, 1'b0, 1'b1,
                            cval_step, color_step, ovf_step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            digit_reg <= '0;
            acc_reg   <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            cval_reg  <= 1'b0;
            color_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            cval_reg  <= cval_next;
            color_reg <= color_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Color stack: push writes the top, a '$' prefetches the entry under it
    mts_ram #(
        .WIDTH (mts_pkg::COLOR_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (take && wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (acc_shift),
        .re    (take && rd_en),
        .raddr (AW'(count_reg - CW'(2))),
        .rdata (rdata)
    );

endmodule

// File: rtl/core/mts_out_fifo.sv
`timescale 1ns / 1ps

module mts_out_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mts_pkg::emit_t                   em,
    input  logic                             out_stall,
    output logic                             out_valid,
    output mts_pkg::seg_t                    head,
    output logic [mts_pkg::OUT_FILL_W-1:0]   fill
);

    mts_pkg::seg_t                     slot_reg [mts_pkg::OUT_DEPTH];
    logic [mts_pkg::OUT_PTR_W-1:0]     wp_reg, wp_next, rp_reg, rp_next, wp1;
    logic [mts_pkg::OUT_FILL_W-1:0]    fill_reg, fill_next;
    logic [1:0]                        n_push;
    logic                              pop;

    assign out_valid = (fill_reg != '0);
    assign head      = slot_reg[rp_reg];
    assign fill      = fill_reg;
    assign pop       = out_valid && !out_stall;
    assign n_push    = {1'b0, em.v[0]} + {1'b0, em.v[1]};
    assign wp1       = wp_reg + mts_pkg::OUT_PTR_W'(1);

    always_comb
    begin
        wp_next   = wp_reg + mts_pkg::OUT_PTR_W'(n_push);
        rp_next   = rp_reg + mts_pkg::OUT_PTR_W'(pop);
        fill_next = fill_reg + mts_pkg::OUT_FILL_W'(n_push) - mts_pkg::OUT_FILL_W'(pop);
    end

    // Pack the two slots in order; the final segment follows a command segment
    always_ff @(posedge clk)
    begin
        if (em.v[0])
        begin
            slot_reg[wp_reg] <= em.item[0];
            if (em.v[1])
            begin
                slot_reg[wp1] <= em.item[1];
            end
        end
        else if (em.v[1])
        begin
            slot_reg[wp_reg] <= em.item[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// File: rtl/core/markup_text_segmenter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Word
// input     in         in_valid / in_stall   char_code, last_char
// output    out        out_valid / out_stall seg_start, seg_end, line_break, has_color,
//                                            color_rgb, stack_overflow, last_segment
// config    in         cfg_we                cfg_index, cfg_data
//
// One character is taken every cycle while in_stall is low; parsing is a single
// registered update of the parser registers and at most one color-stack RAM access per character.
// Segments go to a four-word queue; in_stall rises while it holds three or
// more words, so a character that closes two segments always has room.
// Reset clears the parser and the queue at once; the stack RAM needs no
// clearing, since entries above the stack count are never used.
// A stalled output blocks parsing only once the queue holds three words.

module markup_text_segmenter #(
    parameter int MAX_TEXT    = mts_pkg::MAX_TEXT_DEF,
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mts_pkg::CHAR_W-1:0]    char_code,
    input  logic                          last_char,
    // output words
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mts_pkg::IDX_W-1:0]     seg_start,
    output logic [mts_pkg::IDX_W-1:0]     seg_end,
    output logic                          line_break,
    output logic                          has_color,
    output logic [mts_pkg::COLOR_W-1:0]   color_rgb,
    output logic                          stack_overflow,
    output logic                          last_segment,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mts_pkg::REG_W-1:0]     cfg_data
);

    logic [mts_pkg::REG_W-1:0]       width_reg, height_reg;
    logic                            region_on;
    logic                            in_acc;
    mts_pkg::emit_t                  em;
    mts_pkg::seg_t                   head;
    logic [mts_pkg::OUT_FILL_W-1:0]  fill;

    // Region registers; either one at zero mutes all segments
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mts_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                mts_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign region_on = (width_reg != '0) && (height_reg != '0);

    // Hold input while the queue cannot absorb two more words
    assign in_stall = (fill >= mts_pkg::OUT_STALL_AT);
    assign in_acc   = in_valid && !in_stall;

    mts_parser #(
        .MAX_TEXT    (MAX_TEXT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_acc),
        .char_code (char_code),
        .last_char (last_char),
        .region_on (region_on),
        .em        (em)
    );

    mts_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .em        (em),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .fill      (fill)
    );

    assign seg_start      = head.seg_start;
    assign seg_end        = head.seg_end;
    assign line_break     = head.line_break;
    assign has_color      = head.has_color;
    assign color_rgb      = head.color_rgb;
    assign stack_overflow = head.stack_overflow;
    assign last_segment   = head.last_segment;

    // A muted region never produces a segment
    a_muted: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !region_on) |-> (em.v == 2'b00))
        else $error("segment produced while region is zero");

    // The final segment comes only with an accepted last character
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        em.v[1] |-> (in_acc && last_char))
        else $error("final segment without last character");

    // Segments are produced only for accepted characters
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        em.v[0] |-> in_acc)
        else $error("segment without accepted character");

    // A taken word with nothing new drops the queue by one
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_acc && out_valid && !out_stall) |=> (fill == $past(fill) - 3'd1))
        else $error("queue fill out of step");

endmodule

// File: sim/markup_text_segmenter_checker.sv
`timescale 1ns / 1ps

module markup_text_segmenter_checker
    import mts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic               last_char,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [IDX_W-1:0]   seg_start,
    input  logic [IDX_W-1:0]   seg_end,
    input  logic               line_break,
    input  logic               has_color,
    input  logic [COLOR_W-1:0] color_rgb,
    input  logic               stack_overflow,
    input  logic               last_segment,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [REG_W-1:0]   cfg_data,
    output int                 failures,
    output int                 outstanding
);

    localparam int TEXT_CAP  = MAX_TEXT_DEF;
    localparam int STACK_CAP = STACK_DEPTH_DEF;

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_ESCAPE,
        SCAN_COLOR,
        SCAN_VERBATIM
    } scan_t;

    logic [REG_W-1:0]   region_w;
    logic [REG_W-1:0]   region_h;
    scan_t              scan;
    int                 digit_count;
    logic [COLOR_W-1:0] color_acc;
    int                 position;
    int                 open_first;
    int                 open_past;
    logic               open_has_color;
    logic [COLOR_W-1:0] open_rgb;
    logic [COLOR_W-1:0] colors [STACK_CAP];
    int                 color_depth;
    logic               overflowed;
    seg_t               expected_segments[$];

    function automatic int clamp_pos(input int v);
        return (v > TEXT_CAP) ? TEXT_CAP : v;
    endfunction

    function automatic logic [3:0] digit_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_0 && c <= CH_9)
        begin
            return 4'(c - CH_0);
        end
        if (c >= CH_LA && c <= CH_LF)
        begin
            return 4'(c - CH_LA + 8'd10);
        end
        if (c >= CH_UA && c <= CH_UF)
        begin
            return 4'(c - CH_UA + 8'd10);
        end
        return 4'd0;
    endfunction

    task automatic clear_text();
        scan           = SCAN_TEXT;
        digit_count    = 0;
        color_acc      = '0;
        position       = 0;
        open_first     = 0;
        open_past      = 0;
        open_has_color = 1'b0;
        open_rgb       = '0;
        color_depth    = 0;
        overflowed     = 1'b0;
    endtask

    task automatic open_segment(input int first);
        open_first     = clamp_pos(first);
        open_past      = clamp_pos(first + 1);
        open_has_color = (color_depth > 0);
        open_rgb       = (color_depth > 0) ? colors[color_depth - 1] : '0;
    endtask

    // Close the open segment; nothing is produced while the region is empty
    task automatic close_segment(input int lim, input logic nl, input logic fin);
        seg_t seg;
        int   s;
        int   e;
        if (region_w == '0 || region_h == '0)
        begin
            return;
        end
        s = (open_first > lim) ? lim : open_first;
        e = (open_past > lim) ? lim : open_past;
        if (e < s)
        begin
            e = s;
        end
        seg.seg_start      = IDX_W'(s);
        seg.seg_end        = IDX_W'(e);
        seg.line_break     = nl;
        seg.has_color      = open_has_color;
        seg.color_rgb      = open_has_color ? open_rgb : '0;
        seg.stack_overflow = overflowed;
        seg.last_segment   = fin;
        expected_segments.push_back(seg);
    endtask

    task automatic predict_char(input logic [CHAR_W-1:0] c, input logic fin);
        int p;
        int lim;
        p   = position;
        lim = clamp_pos(p + 1);
        case (scan)
            SCAN_TEXT:
            begin
                if (c != CH_DOLLAR)
                begin
                    open_past = lim;
                end
                else if (!fin)
                begin
                    scan = SCAN_ESCAPE;
                end
            end
            SCAN_ESCAPE:
            begin
                if (c == CH_C)
                begin
                    digit_count = 0;
                    color_acc   = '0;
                    scan        = SCAN_COLOR;
                end
                else if (c == CH_R || c == CH_N)
                begin
                    if (c == CH_R && color_depth > 0)
                    begin
                        color_depth--;
                    end
                    close_segment(lim, c == CH_N, 1'b0);
                    open_segment(p + 1);
                    scan = SCAN_VERBATIM;
                end
                else
                begin
                    close_segment(lim, 1'b0, 1'b0);
                    open_segment(p);
                    scan = SCAN_TEXT;
                end
            end
            SCAN_COLOR:
            begin
                color_acc = {color_acc[COLOR_W-5:0], digit_value(c)};
                digit_count++;
                if (digit_count >= int'(HEX_DIGITS) && !fin)
                begin
                    if (color_depth < STACK_CAP)
                    begin
                        colors[color_depth] = color_acc;
                        color_depth++;
                    end
                    else
                    begin
                        overflowed = 1'b1;
                    end
                    close_segment(lim, 1'b0, 1'b0);
                    open_segment(p + 1);
                    digit_count = 0;
                    scan        = SCAN_VERBATIM;
                end
            end
            default:
            begin
                scan = SCAN_TEXT;
            end
        endcase
        if (fin)
        begin
            close_segment(lim, 1'b0, 1'b1);
            clear_text();
        end
        else if (position < TEXT_CAP)
        begin
            position++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seg_t want;
        if (!rst_n)
        begin
            region_w = '0;
            region_h = '0;
            clear_text();
            expected_segments.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                begin
                    region_w = cfg_data;
                end
                else
                begin
                    region_h = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_char(char_code, last_char);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_segments.size() == 0)
                begin
                    $error("segment with nothing predicted: start %0d end %0d",
                           seg_start, seg_end);
                    failures++;
                end
                else
                begin
                    want = expected_segments.pop_front();
                    check_field("seg_start", 32'(want.seg_start), 32'(seg_start));
                    check_field("seg_end", 32'(want.seg_end), 32'(seg_end));
                    check_field("line_break", 32'(want.line_break), 32'(line_break));
                    check_field("has_color", 32'(want.has_color), 32'(has_color));
                    check_field("color_rgb", 32'(want.color_rgb), 32'(color_rgb));
                    check_field("stack_overflow", 32'(want.stack_overflow),
                                32'(stack_overflow));
                    check_field("last_segment", 32'(want.last_segment),
                                32'(last_segment));
                end
            end
        end
        outstanding = expected_segments.size();
    end

endmodule

// File: sim/markup_text_segmenter_tb.sv
`timescale 1ns / 1ps

module markup_text_segmenter_tb;

    import mts_pkg::*;

    // Generous bound: every word stalled by the longest bursts on both sides,
    // with two segments for every character
    localparam int unsigned CLOCK_LIMIT = 200000;

    typedef enum int {
        TK_PLAIN,
        TK_COLOR,
        TK_POP,
        TK_BREAK,
        TK_DOLLAR,
        TK_UNKNOWN,
        TK_NOISE
    } token_t;

    typedef enum int {
        END_PLAIN,
        END_DANGLING,
        END_CUT_COLOR,
        END_POP,
        END_BREAK
    } ending_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CHAR_W-1:0]  char_code = '0;
    logic               last_char = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [IDX_W-1:0]   seg_start;
    logic [IDX_W-1:0]   seg_end;
    logic               line_break;
    logic               has_color;
    logic [COLOR_W-1:0] color_rgb;
    logic               stack_overflow;
    logic               last_segment;
    logic               cfg_we = 1'b0;
    logic               cfg_index = REG_WIDTH;
    logic [REG_W-1:0]   cfg_data = '0;

    int                 failures;
    int                 outstanding;
    int unsigned        cycle_count = 0;

    // Chance (percent) that a word starts an idle burst on the input side,
    // and that the output side starts a stall burst
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 stall_left = 0;

    logic [CHAR_W-1:0]  text_bytes[$];

    always #2 clk = ~clk;

    markup_text_segmenter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .seg_start      (seg_start),
        .seg_end        (seg_end),
        .line_break     (line_break),
        .has_color      (has_color),
        .color_rgb      (color_rgb),
        .stack_overflow (stack_overflow),
        .last_segment   (last_segment),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    markup_text_segmenter_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .seg_start      (seg_start),
        .seg_end        (seg_end),
        .line_break     (line_break),
        .has_color      (has_color),
        .color_rgb      (color_rgb),
        .stack_overflow (stack_overflow),
        .last_segment   (last_segment),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .failures       (failures),
        .outstanding    (outstanding)
    );

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLOCK_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Output side: stall in random bursts, started only while stall_pct is above 0
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(3, 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Mostly printable, sometimes any byte, never the escape character
    function automatic logic [CHAR_W-1:0] plain_byte();
        logic [CHAR_W-1:0] b;
        do
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                b = CHAR_W'($urandom_range(255, 0));
            end
            else
            begin
                b = CHAR_W'($urandom_range(126, 32));
            end
        end
        while (b == CH_DOLLAR);
        return b;
    endfunction

    // Hex digit in either case; now and then any byte at all, digit or not
    function automatic logic [CHAR_W-1:0] hex_byte();
        string digits;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(9, 0) == 0)
        begin
            return CHAR_W'($urandom_range(255, 0));
        end
        return digits[$urandom_range(21, 0)];
    endfunction

    // The byte after a command is taken as-is, so make it a dollar often
    function automatic logic [CHAR_W-1:0] verbatim_byte();
        return ($urandom_range(2, 0) == 0) ? CH_DOLLAR : plain_byte();
    endfunction

    // Build one text from well-formed escapes with random content, some noise,
    // and one of the ways a text can end (dangling dollar, cut color, ...)
    task automatic compose_text(input int tokens, input bit push_heavy);
        token_t            kind;
        ending_t           ending;
        int                pick;
        logic [CHAR_W-1:0] b;
        text_bytes.delete();
        repeat (tokens)
        begin
            pick = $urandom_range(9, 0);
            if (push_heavy)
            begin
                kind = (pick < 7) ? TK_COLOR : ((pick == 7) ? TK_POP : TK_PLAIN);
            end
            else
            begin
                kind = (pick > int'(TK_NOISE)) ? TK_PLAIN : token_t'(pick);
            end
            case (kind)
                TK_COLOR:
                begin
                    text_bytes.push_back(CH_DOLLAR);
                    text_bytes.push_back(CH_C);
                    repeat (int'(HEX_DIGITS)) text_bytes.push_back(hex_byte());
                    text_bytes.push_back(verbatim_byte());
                end
                TK_POP, TK_BREAK:
                begin
                    text_bytes.push_back(CH_DOLLAR);
                    text_bytes.push_back((kind == TK_POP) ? CH_R : CH_N);
                    text_bytes.push_back(verbatim_byte());
                end
                TK_DOLLAR:
                begin
                    text_bytes.push_back(CH_DOLLAR);
                    text_bytes.push_back(CH_DOLLAR);
                end
                TK_UNKNOWN:
                begin
                    do
                    begin
                        b = CHAR_W'($urandom_range(255, 0));
                    end
                    while (b == CH_C || b == CH_R || b == CH_N);
                    text_bytes.push_back(CH_DOLLAR);
                    text_bytes.push_back(b);
                end
                TK_NOISE:
                begin
                    repeat ($urandom_range(3, 1))
                    begin
                        b = ($urandom_range(3, 0) == 0) ? CH_DOLLAR
                                                        : CHAR_W'($urandom_range(255, 0));
                        text_bytes.push_back(b);
                    end
                end
                default:
                begin
                    repeat ($urandom_range(5, 1)) text_bytes.push_back(plain_byte());
                end
            endcase
        end
        pick = $urandom_range(7, 0);
        ending = (pick > int'(END_BREAK)) ? END_PLAIN : ending_t'(pick);
        case (ending)
            END_DANGLING:
            begin
                text_bytes.push_back(CH_DOLLAR);
            end
            END_CUT_COLOR:
            begin
                // zero to six digits; even six leave the color cut, as the last byte ends the text
                text_bytes.push_back(CH_DOLLAR);
                text_bytes.push_back(CH_C);
                repeat ($urandom_range(int'(HEX_DIGITS), 0)) text_bytes.push_back(hex_byte());
            end
            END_POP, END_BREAK:
            begin
                text_bytes.push_back(CH_DOLLAR);
                text_bytes.push_back((ending == END_POP) ? CH_R : CH_N);
            end
            default:
            begin
            end
        endcase
        if (text_bytes.size() == 0)
        begin
            text_bytes.push_back(plain_byte());
        end
    endtask

    // Offer one word and hold it until the block takes it. Call at a rising
    // edge; return at the edge that accepted the word.
    task automatic feed_char(input logic [CHAR_W-1:0] c, input logic fin);
        bit taken;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= fin;
        // sample the stall away from the edge where it may change
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic feed_text();
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            feed_char(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    task automatic load_string(input string s);
        text_bytes.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            text_bytes.push_back(s[i]);
        end
    endtask

    // Drop valid, wait for every predicted segment, then let characters
    // that close nothing finish too
    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    // Both registers, width then height, in back-to-back writes; only while the block is idle
    task automatic program_region(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random texts until about the given number of words has gone in
    task automatic run_texts(input int budget, input int pct);
        int fed;
        fed = 0;
        while (fed < budget)
        begin
            // leave a quarter of the texts with no idling on either side
            idle_pct  = ($urandom_range(3, 0) == 0) ? 0 : pct;
            stall_pct = idle_pct;
            if ($urandom_range(7, 0) == 0)
            begin
                // enough pushes to run past a full color stack
                compose_text($urandom_range(30, 20), 1'b1);
            end
            else
            begin
                compose_text($urandom_range(10, 1), 1'b0);
            end
            feed_text();
            fed += text_bytes.size();
        end
        settle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Region still zero from reset: parsing runs, nothing comes out
        run_texts(50, 20);

        // Directed texts with the full region
        program_region('1, '1);
        idle_pct  = 0;
        stall_pct = 0;
        // byte extremes
        text_bytes.delete();
        text_bytes.push_back(8'h00);
        text_bytes.push_back(CH_UA);
        text_bytes.push_back(8'hFF);
        feed_text();
        // push with mixed case and a bad digit, newline, unknown letter,
        // escaped dollar, pop on the last byte
        load_string("$cFf0aZ9x$nx$q$$$r");
        feed_text();
        // pop on an empty stack, then a color cut off by the end of text
        load_string("$r$c1");
        feed_text();
        // lone dangling dollar
        load_string("$");
        feed_text();
        settle();

        // Width zero alone, then the smallest region, then height zero alone
        program_region('0, '1);
        run_texts(70, 30);
        program_region(REG_W'(1), REG_W'(1));
        run_texts(250, 40);
        program_region('1, '0);
        run_texts(70, 30);

        // Random region under heavy idling
        program_region(REG_W'($urandom_range(4095, 1)), REG_W'($urandom_range(4095, 1)));
        run_texts(450, 50);

        // Full region again with moderate idling
        program_region('1, '1);
        run_texts(450, 25);

        // Closing stretch with no idling on either side
        program_region(REG_W'($urandom_range(4095, 1)), REG_W'($urandom_range(4095, 1)));
        run_texts(400, 0);

        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/mts_pkg.sv
rtl/core/mts_ram.sv
rtl/core/mts_parser.sv
rtl/core/mts_out_fifo.sv
rtl/core/markup_text_segmenter.sv
sim/markup_text_segmenter_checker.sv
sim/markup_text_segmenter_tb.sv
